[rtl/core/bzc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_pkg: shared types and tables of the back-EMF commutator
// Widths of the tick counter and delay logic, phase drive codes and the
// six-step drive table shared by the datapath and the top level.
// ----------------------------------------------------------------------------
package bzc_pkg;

	// Tick counter and average width; delay and lag counters are four bits narrower (1/16 of its range).
	localparam int CNT_W    = 15;
	localparam int LAG_W    = CNT_W - 4;
	localparam int PERIOD_W = 15;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [LAG_W-1:0] LAG_MAX = {LAG_W{1'b1}};

	// Per-phase drive codes.
	typedef enum logic [1:0] {
		DRV_OFF = 2'd0,
		DRV_LOW = 2'd1,
		DRV_PWM = 2'd2
	} drive_t;

	typedef struct packed {
		drive_t u;
		drive_t v;
		drive_t w;
	} phase_drive_t;

	// One processed tick as it leaves the datapath.
	typedef struct packed {
		logic [2:0]          raw_hall;
		logic [2:0]          delayed_hall;
		phase_drive_t        drive;
		logic [PERIOD_W-1:0] period_estimate;
	} result_t;

	// Six-step drive table indexed by the delayed hall code.
	function automatic phase_drive_t drive_lookup(input logic [2:0] hall);
		phase_drive_t d;
		d = '{u: DRV_OFF, v: DRV_OFF, w: DRV_OFF};
		case (hall)
			3'd1: d = '{u: DRV_PWM, v: DRV_LOW, w: DRV_OFF};
			3'd2: d = '{u: DRV_LOW, v: DRV_OFF, w: DRV_PWM};
			3'd3: d = '{u: DRV_OFF, v: DRV_LOW, w: DRV_PWM};
			3'd4: d = '{u: DRV_OFF, v: DRV_PWM, w: DRV_LOW};
			3'd5: d = '{u: DRV_PWM, v: DRV_OFF, w: DRV_LOW};
			3'd6: d = '{u: DRV_LOW, v: DRV_PWM, w: DRV_OFF};
			default: d = '{u: DRV_OFF, v: DRV_OFF, w: DRV_OFF};
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

[rtl/core/bzc_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_datapath: per-tick sensor filter, period estimator and commutation delay
// Holds the virtual sensor, tick, average, delay and lag state and computes
// the result of one tick from a registered pair of comparator samples.
// ----------------------------------------------------------------------------
module bzc_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire                  direction,
	input  wire [2:0]            first_s1,
	input  wire [2:0]            second_s1,
	output bzc_pkg::result_t     result
);
	import bzc_pkg::*;

	logic [2:0]       sensor_q;
	logic [CNT_W-1:0] tick_q;
	logic [CNT_W-1:0] avg_q;
	logic [LAG_W-1:0] delay_q;
	logic [LAG_W-1:0] lag_q;
	logic [2:0]       held_q;

	logic [2:0]       both_high;
	logic [2:0]       both_low;
	logic             w_clear;
	logic [CNT_W-1:0] tick_inc;
	logic [CNT_W-1:0] tick_nxt;
	logic [CNT_W-1:0] avg_nxt;
	logic [CNT_W:0]   down_step;
	logic [LAG_W-1:0] delay_nxt;
	logic [2:0]       sensor_nxt;
	logic [2:0]       raw;
	logic [LAG_W-1:0] lag_inc;
	logic [LAG_W-1:0] lag_nxt;
	logic [2:0]       held_nxt;

	// Comparator filter: both samples must agree before a sensor changes.
	assign both_high = first_s1 & second_s1;
	assign both_low  = ~(first_s1 | second_s1);
	assign w_clear   = sensor_q[0] & both_high[0];

	always_comb begin
		sensor_nxt = (sensor_q & ~both_high) | both_low;
	end

	// Saturating tick count, restarted by a phase W clear event.
	assign tick_inc = (tick_q < CNT_MAX) ? tick_q + 1'b1 : tick_q;
	assign tick_nxt = w_clear ? '0 : tick_inc;

	// Quarter-gain average; the downward step rounds toward the count.
	assign down_step = ({1'b0, avg_q} - {1'b0, tick_inc}) + (CNT_W + 1)'(3);

	always_comb begin
		avg_nxt = avg_q;
		if (w_clear) begin
			if (tick_inc >= avg_q) begin
				avg_nxt = avg_q + ((tick_inc - avg_q) >> 2);
			end else begin
				avg_nxt = avg_q - CNT_W'(down_step >> 2);
			end
		end
	end

	assign delay_nxt = w_clear ? avg_nxt[CNT_W-1:4] : delay_q;

	// Hall code ordered by direction, inverted in reverse.
	always_comb begin
		if (direction) begin
			raw = {sensor_nxt[0], sensor_nxt[2], sensor_nxt[1]};
		end else begin
			raw = ~{sensor_nxt[1], sensor_nxt[0], sensor_nxt[2]};
		end
	end

	// Commutation delay: adopt a differing code once the lag reaches the delay.
	assign lag_inc = (lag_q < LAG_MAX) ? lag_q + 1'b1 : lag_q;

	always_comb begin
		lag_nxt  = lag_q;
		held_nxt = held_q;
		if (raw != held_q) begin
			if (lag_inc >= delay_nxt) begin
				held_nxt = raw;
				lag_nxt  = '0;
			end else begin
				lag_nxt = lag_inc;
			end
		end
	end

	// State update, one tick per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_q <= '0;
			tick_q   <= '0;
			avg_q    <= '0;
			delay_q  <= '0;
			lag_q    <= '0;
			held_q   <= '0;
		end else if (step) begin
			sensor_q <= sensor_nxt;
			tick_q   <= tick_nxt;
			avg_q    <= avg_nxt;
			delay_q  <= delay_nxt;
			lag_q    <= lag_nxt;
			held_q   <= held_nxt;
		end
	end

	// Result of this tick, taken into the output register by the top level.
	always_comb begin
		result.raw_hall        = raw;
		result.delayed_hall    = held_nxt;
		result.drive           = drive_lookup(held_nxt);
		result.period_estimate = PERIOD_W'(avg_nxt);
	end

	// The delay always tracks one sixteenth of the average.
	a_delay_tracks_avg: assert property (@(posedge clk) disable iff (!arst_n)
		delay_q == avg_q[CNT_W-1:4])
		else $error("delay out of step with period average");

	// The held code only moves when the lag counter restarts.
	a_held_moves_with_lag: assert property (@(posedge clk) disable iff (!arst_n)
		step && (held_nxt != held_q) |=> lag_q == '0)
		else $error("hall code adopted without lag restart");

endmodule
`default_nettype wire

[rtl/core/bemf_zero_cross_commutator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_zero_cross_commutator: sensorless six-step commutator
// Filters back-EMF comparator samples into virtual hall sensors, estimates
// the electrical period and drives the six-step phase table after a delay.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries the two comparator samples of
// one tick and produces exactly one result transfer. The block takes one
// tick per clock while the output is not stalled: the samples are registered,
// processed combinationally by the datapath and written into the output
// register. A new tick is accepted while a result waits, as long as the
// output register can make room; a stalled output holds at most one more
// tick in the input register. The user must write the direction register
// only between ticks, with no tick in flight; the block does not enforce it.
module bemf_zero_cross_commutator (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_wr_en,
	input  wire                          cfg_wr_data,
	// sample channel
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [2:0]                   first_sample,
	input  wire  [2:0]                   second_sample,
	// result channel
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [2:0]                   raw_hall,
	output logic [2:0]                   delayed_hall,
	output logic [1:0]                   drive_u,
	output logic [1:0]                   drive_v,
	output logic [1:0]                   drive_w,
	output logic [bzc_pkg::PERIOD_W-1:0] period_estimate
);
	import bzc_pkg::*;

	logic       direction_q;
	logic       valid_s1;
	logic [2:0] first_s1;
	logic [2:0] second_s1;
	logic       advance;
	logic       in_take;
	logic       out_valid_q;
	result_t    result;
	result_t    result_q;

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
		end
	end

	// The input stage moves on whenever the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			first_s1  <= first_sample;
			second_s1 <= second_sample;
		end
	end

	// Per-tick state update.
	bzc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.direction (direction_q),
		.first_s1  (first_s1),
		.second_s1 (second_s1),
		.result    (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign raw_hall        = result_q.raw_hall;
	assign delayed_hall    = result_q.delayed_hall;
	assign drive_u         = result_q.drive.u;
	assign drive_v         = result_q.drive.v;
	assign drive_w         = result_q.drive.w;
	assign period_estimate = result_q.period_estimate;

	// A stall at the input means a tick is parked in the input register.
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room downstream");

	// Every tick that leaves the input stage shows up as a result.
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed tick lost before output");

	// Codes zero and seven turn every phase off.
	a_idle_codes_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (result_q.delayed_hall == 3'd0 || result_q.delayed_hall == 3'd7)
		|-> result_q.drive.u == DRV_OFF && result_q.drive.v == DRV_OFF
			&& result_q.drive.w == DRV_OFF)
		else $error("phase driven on an idle hall code");

endmodule
`default_nettype wire

[tb/sv/bemf_zero_cross_commutator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bemf_zero_cross_commutator_tb: self-checking testbench of the commutator
// Drives comparator sample pairs through the valid/stall input channel and
// checks every result transfer against a cycle-free model of the sensor
// filter, period average, commutation delay and six-step drive table. The
// run covers both direction settings, three idle profiles of rotor-like
// sample sequences and random noise, and a short stalled rotor followed by a
// fast spin against the longer delay it leaves behind.
// ----------------------------------------------------------------------------

// Tracks the commutator state per accepted tick and checks the results.
class commutation_scoreboard;

	bit                          direction;
	bit [2:0]                    sensors;
	bit [bzc_pkg::CNT_W-1:0]     ticks;
	bit [bzc_pkg::CNT_W-1:0]     period_avg;
	bit [bzc_pkg::LAG_W-1:0]     delay_ticks;
	bit [bzc_pkg::LAG_W-1:0]     lag_ticks;
	bit [2:0]                    held_code;
	bzc_pkg::result_t            expected_ticks[$];
	int                          mismatches;
	int                          checked;
	int                          accepted;
	int                          w_clears;
	int                          peak_period;
	bit                          saturated;

	function new();
		direction   = 1'b0;
		sensors     = '0;
		ticks       = '0;
		period_avg  = '0;
		delay_ticks = '0;
		lag_ticks   = '0;
		held_code   = '0;
		mismatches  = 0;
		checked     = 0;
		accepted    = 0;
		w_clears    = 0;
		peak_period = 0;
		saturated   = 1'b0;
	endfunction

	function int pending();
		return expected_ticks.size();
	endfunction

	// Phase drives selected by a hall code; codes 0 and 7 leave all phases off.
	function bzc_pkg::phase_drive_t six_step(input bit [2:0] code);
		bzc_pkg::phase_drive_t d;
		d.u = bzc_pkg::DRV_OFF;
		d.v = bzc_pkg::DRV_OFF;
		d.w = bzc_pkg::DRV_OFF;
		case (code)
			3'd1: begin
				d.u = bzc_pkg::DRV_PWM;
				d.v = bzc_pkg::DRV_LOW;
			end
			3'd2: begin
				d.u = bzc_pkg::DRV_LOW;
				d.w = bzc_pkg::DRV_PWM;
			end
			3'd3: begin
				d.v = bzc_pkg::DRV_LOW;
				d.w = bzc_pkg::DRV_PWM;
			end
			3'd4: begin
				d.v = bzc_pkg::DRV_PWM;
				d.w = bzc_pkg::DRV_LOW;
			end
			3'd5: begin
				d.u = bzc_pkg::DRV_PWM;
				d.w = bzc_pkg::DRV_LOW;
			end
			3'd6: begin
				d.u = bzc_pkg::DRV_LOW;
				d.v = bzc_pkg::DRV_PWM;
			end
			default: begin
			end
		endcase
		return d;
	endfunction

	// Advances the model by one accepted tick and queues the result it causes.
	function void predict_tick(input bit [2:0] first, input bit [2:0] second);
		bit [2:0]                both_high;
		bit [2:0]                both_low;
		bit [2:0]                code;
		bit [bzc_pkg::CNT_W:0]   shortfall;
		bzc_pkg::result_t        r;
		both_high = first & second;
		both_low  = ~(first | second);
		accepted++;

		if (ticks != bzc_pkg::CNT_MAX)
			ticks++;
		else
			saturated = 1'b1;

		// Clearing the phase W sensor closes one period measurement.
		if (sensors[0] && both_high[0]) begin
			sensors[0] = 1'b0;
			if (ticks >= period_avg) begin
				period_avg = period_avg + ((ticks - period_avg) >> 2);
			end else begin
				shortfall  = {1'b0, period_avg} - {1'b0, ticks}
					+ (bzc_pkg::CNT_W + 1)'(3);
				period_avg = period_avg - shortfall[bzc_pkg::CNT_W:2];
			end
			ticks       = '0;
			delay_ticks = period_avg[bzc_pkg::CNT_W-1:4];
			w_clears++;
			if (period_avg > peak_period)
				peak_period = period_avg;
		end else if (!sensors[0] && both_low[0]) begin
			sensors[0] = 1'b1;
		end
		sensors[2:1] = (sensors[2:1] & ~both_high[2:1]) | both_low[2:1];

		// Forward orders the code as W,U,V; reverse as V,W,U and inverts it.
		if (direction)
			code = {sensors[0], sensors[2], sensors[1]};
		else
			code = ~{sensors[1], sensors[0], sensors[2]};

		// The held code follows once the raw code has differed long enough.
		if (code != held_code) begin
			if (lag_ticks != bzc_pkg::LAG_MAX)
				lag_ticks++;
			if (lag_ticks >= delay_ticks) begin
				held_code = code;
				lag_ticks = '0;
			end
		end

		r.raw_hall        = code;
		r.delayed_hall    = held_code;
		r.drive           = six_step(held_code);
		r.period_estimate = period_avg;
		expected_ticks.push_back(r);
	endfunction

	function void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result %0d field %s expected %0d got %0d",
					checked, field, want, got);
		end
	endfunction

	// Compares one result transfer with the oldest queued expectation.
	function void check_result(input bit [2:0] raw, input bit [2:0] delayed,
			input bit [1:0] du, input bit [1:0] dv, input bit [1:0] dw,
			input bit [bzc_pkg::PERIOD_W-1:0] period);
		bzc_pkg::result_t want;
		if (expected_ticks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result transfer with no tick pending (raw %0d)", raw);
			return;
		end
		want = expected_ticks.pop_front();
		compare_field("raw_hall", want.raw_hall, raw);
		compare_field("delayed_hall", want.delayed_hall, delayed);
		compare_field("drive_u", want.drive.u, du);
		compare_field("drive_v", want.drive.v, dv);
		compare_field("drive_w", want.drive.w, dw);
		compare_field("period_estimate", want.period_estimate, period);
		checked++;
	endfunction

endclass

module bemf_zero_cross_commutator_tb;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int STALL_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_TICKS    = 260;
	localparam int STALLED_TICKS  = 40;
	localparam int DIRECTED_TICKS = 24;

	// Sensor pattern of one electrical revolution, bits U,V,W; one bit per step.
	localparam logic [2:0] SENSOR_SEQ [6] = '{3'b001, 3'b011, 3'b010,
		3'b110, 3'b100, 3'b101};

	// Directed sample pairs {first, second}: the first half runs forward.
	localparam logic [5:0] DIRECTED [DIRECTED_TICKS] = '{
		{3'd0, 3'd0}, {3'd7, 3'd7}, {3'd0, 3'd7}, {3'd7, 3'd0},
		{3'd6, 3'd6}, {3'd5, 3'd5}, {3'd3, 3'd3}, {3'd1, 3'd1},
		{3'd2, 3'd2}, {3'd4, 3'd4}, {3'd5, 3'd2}, {3'd2, 3'd5},
		{3'd0, 3'd0}, {3'd7, 3'd7}, {3'd6, 3'd6}, {3'd4, 3'd4},
		{3'd5, 3'd5}, {3'd1, 3'd1}, {3'd3, 3'd3}, {3'd2, 3'd2},
		{3'd0, 3'd0}, {3'd7, 3'd7}, {3'd6, 3'd1}, {3'd1, 3'd6}
	};

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       cfg_wr_en     = 1'b0;
	logic       cfg_wr_data   = 1'b0;
	logic       in_valid      = 1'b0;
	logic [2:0] first_sample  = 3'd0;
	logic [2:0] second_sample = 3'd0;
	logic       out_stall     = 1'b0;

	wire                           in_stall;
	wire                           out_valid;
	wire [2:0]                     raw_hall;
	wire [2:0]                     delayed_hall;
	wire [1:0]                     drive_u;
	wire [1:0]                     drive_v;
	wire [1:0]                     drive_w;
	wire [bzc_pkg::PERIOD_W-1:0]   period_estimate;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int quiet_left   = 0;
	int idle_cycles  = 0;

	commutation_scoreboard commutation_sb = new();

	bemf_zero_cross_commutator u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.first_sample    (first_sample),
		.second_sample   (second_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.raw_hall        (raw_hall),
		.delayed_hall    (delayed_hall),
		.drive_u         (drive_u),
		.drive_v         (drive_v),
		.drive_w         (drive_w),
		.period_estimate (period_estimate)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Result stalls; now and then a quiet stretch with no idling on either side.
	always @(posedge clk) begin
		if (quiet_left > 0) begin
			quiet_left <= quiet_left - 1;
			out_stall  <= 1'b0;
		end else begin
			if ($urandom_range(199) == 0)
				quiet_left <= $urandom_range(40, 10);
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Watch both channels for transfers.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				commutation_sb.check_result(raw_hall, delayed_hall, drive_u, drive_v,
					drive_w, period_estimate);
			if (in_valid && !in_stall)
				commutation_sb.predict_tick(first_sample, second_sample);
		end
	end

	// End the run when no transfer happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("ERROR: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, commutation_sb.pending());
			$display("** bemf_zero_cross_commutator: FAILED **");
			$finish;
		end
	end

	// Offers one tick and holds it until the transfer, then maybe idles.
	task automatic send_tick(input logic [2:0] first, input logic [2:0] second);
		in_valid      <= 1'b1;
		first_sample  <= first;
		second_sample <= second;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		while (quiet_left == 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops offering ticks and waits until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (commutation_sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_direction(input logic dir);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= dir;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		commutation_sb.direction = dir;
	endtask

	// Rotor-like samples: six-step sensor pattern with jittered dwell and noise.
	task automatic spin_segment(input int n_ticks, input int dwell_base, input int noise_pct);
		int         step;
		int         dwell;
		bit         fwd;
		logic [2:0] first;
		logic [2:0] second;
		fwd   = $urandom_range(1);
		step  = $urandom_range(5);
		dwell = $urandom_range(dwell_base, 1);
		for (int i = 0; i < n_ticks; i++) begin
			if (dwell == 0) begin
				step  = fwd ? (step + 1) % 6 : (step + 5) % 6;
				dwell = dwell_base + $urandom_range(1);
			end
			dwell--;
			// A sensor is set by two low samples and cleared by two high ones.
			first  = ~SENSOR_SEQ[step];
			second = ~SENSOR_SEQ[step];
			if ($urandom_range(99) < noise_pct)
				first = first ^ 3'($urandom_range(7));
			if ($urandom_range(99) < noise_pct / 2)
				second = second ^ 3'($urandom_range(7));
			send_tick(first, second);
		end
	endtask

	task automatic noise_segment(input int n_ticks);
		logic [2:0] first;
		for (int i = 0; i < n_ticks; i++) begin
			first = 3'($urandom_range(7));
			if ($urandom_range(1) == 0)
				send_tick(first, first);
			else
				send_tick(first, 3'($urandom_range(7)));
		end
	endtask

	// Phase W held cleared so the tick counter keeps running.
	task automatic stalled_rotor(input int n_ticks);
		for (int i = 0; i < n_ticks; i++)
			send_tick({2'($urandom_range(3)), 1'b1}, {2'($urandom_range(3)), 1'b1});
	endtask

	// One idle profile: mostly rotor sequences, some noise, direction flipped midway.
	task automatic run_phase(input int tx_pct, input int rx_pct, input logic dir);
		int sent;
		int len;
		int band;
		int base;
		bit flipped;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		set_direction(dir);
		sent    = 0;
		flipped = 1'b0;
		while (sent < PHASE_TICKS) begin
			if (!flipped && sent >= PHASE_TICKS / 2) begin
				set_direction(~dir);
				flipped = 1'b1;
			end
			len = $urandom_range(80, 30);
			if ($urandom_range(9) < 7) begin
				band = $urandom_range(9);
				if (band < 4)
					base = $urandom_range(3, 1);
				else if (band < 8)
					base = $urandom_range(12, 4);
				else
					base = $urandom_range(40, 13);
				len = len + 6 * base;
				spin_segment(len, base, 10);
			end else begin
				noise_segment(len);
			end
			sent += len;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme and disagreeing samples, each sensor set and cleared.
		set_direction(1'b1);
		for (int i = 0; i < DIRECTED_TICKS; i++) begin
			if (i == DIRECTED_TICKS / 2)
				set_direction(1'b0);
			send_tick(DIRECTED[i][5:3], DIRECTED[i][2:0]);
		end

		run_phase(38, 76, 1'b0);
		run_phase(76, 38, 1'b1);
		run_phase(0, 0, 1'b0);

		// Hold the rotor still for a while, then spin fast against the delay.
		stalled_rotor(STALLED_TICKS);
		spin_segment(60, 2, 10);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d ticks and %0d checked results in both directions,",
			commutation_sb.accepted, commutation_sb.checked);
		$display("%0d mismatches; phase W clears: %0d, peak period estimate %0d.",
			commutation_sb.mismatches, commutation_sb.w_clears,
			commutation_sb.peak_period);
		if (commutation_sb.mismatches == 0 && commutation_sb.pending() == 0)
			$display("** bemf_zero_cross_commutator: PASSED **");
		else
			$display("** bemf_zero_cross_commutator: FAILED **");
		$finish;
	end

endmodule
